// File: hw/rtl/ssid_pkg.sv
// ----------------------------------------------------------------------------
// ssid_pkg: shared types for the sorted set
// Opcodes, channel payloads and the control word broadcast to the cell row.
// ----------------------------------------------------------------------------
package ssid_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_ASCEND  = 2'd2,
    OP_DESCEND = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  element;
    logic                      present;
    logic                      last;
  } rsp_t;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic                      ins;
    logic                      del;
    logic                      rot_l;
    logic                      rot_r;
    logic signed [DATA_W-1:0]  key;
  } ctl_t;

endpackage

// File: hw/rtl/ssid_stream_if.sv
// ----------------------------------------------------------------------------
// ssid_stream_if: valid/ready stream channel
// One transfer per clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ssid_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/ssid_cell.sv
// ----------------------------------------------------------------------------
// ssid_cell: one slot of the sorted row
// Holds one value; keeps it, takes the key, takes a neighbor's value, or takes the wrapped head or tail.
// ----------------------------------------------------------------------------
module ssid_cell (
  input  logic                              clk,
  input  ssid_pkg::ctl_t                    ctl,
  input  logic                              occ,
  input  logic                              left_lt,
  input  logic signed [ssid_pkg::DATA_W-1:0] left_val,
  input  logic signed [ssid_pkg::DATA_W-1:0] right_val,
  input  logic                              wrap_sel,
  input  logic signed [ssid_pkg::DATA_W-1:0] wrap_val,
  output logic signed [ssid_pkg::DATA_W-1:0] val,
  output logic                              lt,
  output logic                              eq
);

  logic signed [ssid_pkg::DATA_W-1:0] val_next;

  assign lt = occ && (val < ctl.key);
  assign eq = occ && (val == ctl.key);

  always_comb begin
    val_next = val;
    if (ctl.ins) begin
      // cells below the key stay; the first one above takes the key, the rest take their left neighbor's value
      if (!lt) begin
        val_next = left_lt ? ctl.key : left_val;
      end
    end else if (ctl.del) begin
      if (!lt) begin
        val_next = right_val;
      end
    end else if (ctl.rot_l) begin
      val_next = wrap_sel ? wrap_val : right_val;
    end else if (ctl.rot_r) begin
      val_next = wrap_sel ? wrap_val : left_val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// File: hw/rtl/ssid_chain.sv
// ----------------------------------------------------------------------------
// ssid_chain: row of cells plus fill count
// Gates insert/delete on duplicate, full and miss; exposes head and tail.
// ----------------------------------------------------------------------------
module ssid_chain #(
  parameter int CAPACITY = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ssid_pkg::ctl_t                     ctl,
  output logic [$clog2(CAPACITY+1)-1:0]      count,
  output logic signed [ssid_pkg::DATA_W-1:0] head,
  output logic signed [ssid_pkg::DATA_W-1:0] tail
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [ssid_pkg::DATA_W-1:0] vals [CAPACITY];
  logic [CAPACITY-1:0]                lt_vec;
  logic [CAPACITY-1:0]                eq_vec;
  logic                               found;
  logic                               full;
  ssid_pkg::ctl_t                     cell_ctl;
  logic [CW-1:0]                      count_next;
  logic [IW-1:0]                      tail_idx;

  assign found = |eq_vec;
  assign full  = (count == CW'(CAPACITY));

  always_comb begin
    cell_ctl     = ctl;
    cell_ctl.ins = ctl.ins && !found && !full;
    cell_ctl.del = ctl.del && found;
  end

  always_comb begin
    count_next = count;
    if (cell_ctl.ins) begin
      count_next = count + CW'(1);
    end else if (cell_ctl.del) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign head     = vals[0];
  assign tail_idx = count[IW-1:0] - IW'(1);

  always_comb begin
    tail = vals[0];
    for (int i = 0; i < CAPACITY; i++) begin
      if (tail_idx == IW'(i)) begin
        tail = vals[i];
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                               left_lt;
    logic signed [ssid_pkg::DATA_W-1:0] left_val;
    logic signed [ssid_pkg::DATA_W-1:0] right_val;
    logic                               wrap_sel;
    logic signed [ssid_pkg::DATA_W-1:0] wrap_val;

    // nothing to the left of cell zero: it takes the key when not below it
    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_val = '0;
    end else begin : g_mid
      assign left_lt  = lt_vec[i-1];
      assign left_val = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_inner
      assign right_val = vals[i+1];
    end

    // left rotate wraps the head into the top occupied cell,
    // right rotate wraps the tail into cell zero
    assign wrap_sel = ctl.rot_r ? (i == 0) : (count == CW'(i + 1));
    assign wrap_val = ctl.rot_r ? tail : head;

    ssid_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .occ       (count > CW'(i)),
      .left_lt   (left_lt),
      .left_val  (left_val),
      .right_val (right_val),
      .wrap_sel  (wrap_sel),
      .wrap_val  (wrap_val),
      .val       (vals[i]),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i])
    );
  end

endmodule

// File: hw/rtl/sorted_set_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_set_insert_delete: ordered set of distinct signed 32-bit values
// Insert/delete update the row at the accepting edge; a readout's first result
//   is registered once the output slot is free after acceptance.
// Insert/delete are accepted 1 per cycle while no readout is streaming; a
//   readout holds off input until its last entry has been loaded for output.
// Reset: synchronous; empties the set and drops any pending result.
// ----------------------------------------------------------------------------
module sorted_set_insert_delete #(
  parameter int CAPACITY = 32
) (
  input  logic          clk,
  input  logic          rst,
  ssid_stream_if.sink   req,
  ssid_stream_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  // FSM: IDLE takes commands, STREAM walks the row out through rsp
  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_STREAM = 2'b10
  } state_t;

  state_t                             state;
  state_t                             state_next;
  ssid_pkg::req_t                     req_data;
  ssid_pkg::ctl_t                     ctl;
  logic                               req_xfer;
  logic                               is_readout;
  logic                               load;
  logic                               desc;
  logic                               empty;
  logic [CW-1:0]                      remaining;
  logic [CW-1:0]                      count;
  logic signed [ssid_pkg::DATA_W-1:0] head;
  logic signed [ssid_pkg::DATA_W-1:0] tail;
  logic                               out_valid;
  ssid_pkg::rsp_t                     out_data;

  assign req_data  = req.data;
  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign is_readout = (req_data.opcode == ssid_pkg::OP_ASCEND) ||
                      (req_data.opcode == ssid_pkg::OP_DESCEND);

  // While streaming, the output slot loads whenever it is empty or being drained this cycle
  assign load = (state == S_STREAM) && (!out_valid || rsp.ready);

  // Row control: edits on the accepting edge, rotation per emitted entry.
  // After one rotation per stored entry the row is back in its original order.
  always_comb begin
    ctl.ins   = req_xfer && (req_data.opcode == ssid_pkg::OP_INSERT);
    ctl.del   = req_xfer && (req_data.opcode == ssid_pkg::OP_DELETE);
    ctl.rot_l = load && !empty && !desc;
    ctl.rot_r = load && !empty && desc;
    ctl.key   = req_data.value;
  end

  ssid_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .count (count),
    .head  (head),
    .tail  (tail)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_xfer && is_readout) begin
          state_next = S_STREAM;
        end
      end
      S_STREAM: begin
        if (load && (remaining == CW'(1))) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Readout bookkeeping; an empty set still gives one transfer
  always_ff @(posedge clk) begin
    if (req_xfer && is_readout) begin
      desc      <= (req_data.opcode == ssid_pkg::OP_DESCEND);
      empty     <= (count == '0);
      remaining <= (count == '0) ? CW'(1) : count;
    end else if (load) begin
      remaining <= remaining - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.element <= empty ? '0 : (desc ? tail : head);
      out_data.present <= !empty;
      out_data.last    <= (remaining == CW'(1));
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule
